// ===== sv/nhsf_pkg.sv =====
// ---------------------------------------------------------------------------
// nhsf_pkg: shared types, constants and control store of the slot finder
// Holds the beat structs, the step and condition codes and the microprogram.
// ---------------------------------------------------------------------------
package nhsf_pkg;

    // Default table depth and fixed arithmetic constants
    localparam int unsigned TABLE_SLOTS_DEF = 1024;
    localparam logic [31:0] HASH_MULT       = 32'd13131;
    localparam int unsigned DVD_W           = 31;  // hash bits kept before the modulo
    localparam int unsigned IDX_EXT_W       = 17;  // holds any slot index up to 65536
    localparam int unsigned DESC_W          = 10;

    typedef enum logic [1:0] {
        OP_NAME_BYTE = 2'd0,
        OP_MARK_USED = 2'd1,
        OP_MARK_FREE = 2'd2,
        OP_RSVD      = 2'd3
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [7:0] name_byte;
        logic       last_byte;
        logic [9:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [9:0] descriptor;
        logic       table_full;
    } t_out;

    // Program steps
    typedef enum logic [3:0] {
        ST_CLEAR      = 4'd0,
        ST_IDLE       = 4'd1,
        ST_DECODE     = 4'd2,
        ST_CHK_RSVD   = 4'd3,
        ST_HASH       = 4'd4,
        ST_MOD_MUL    = 4'd5,
        ST_MOD_SUB    = 4'd6,
        ST_PROBE_INIT = 4'd7,
        ST_PROBE_READ = 4'd8,
        ST_PROBE_CHK  = 4'd9,
        ST_PROBE_ADV  = 4'd10,
        ST_EMIT_FULL  = 4'd11,
        ST_EMIT_FOUND = 4'd12,
        ST_MARK       = 4'd13
    } t_step;

    // Jump conditions: jump to target when true, else fall to the next step
    typedef enum logic [3:0] {
        C_NEXT      = 4'd0,
        C_ALWAYS    = 4'd1,
        C_NOT_START = 4'd2,
        C_IS_MARK   = 4'd3,
        C_IS_RSVD   = 4'd4,
        C_NOT_LAST  = 4'd5,
        C_SLOT_FREE = 4'd6,
        C_CNT_MORE  = 4'd7
    } t_cond;

    typedef struct packed {
        logic  busy;
        logic  latch;
        logic  hash_en;
        logic  mod_mul;
        logic  mod_sub;
        logic  probe_init;
        logic  probe_adv;
        logic  clr_wr;
        logic  mark_wr;
        logic  emit_full;
        logic  emit_found;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic is_mark;
        logic is_rsvd;
        logic not_last;
        logic slot_free;
        logic cnt_more;
    } t_stat;

    // Control store: one control word per step
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl c;
        c        = '0;
        c.busy   = 1'b1;
        c.cond   = C_NEXT;
        c.target = ST_IDLE;
        case (step)
            ST_CLEAR: begin
                c.clr_wr = 1'b1;
                c.cond   = C_CNT_MORE;
                c.target = ST_CLEAR;
            end
            ST_IDLE: begin
                c.busy   = 1'b0;
                c.latch  = 1'b1;
                c.cond   = C_NOT_START;
                c.target = ST_IDLE;
            end
            ST_DECODE: begin
                c.cond   = C_IS_MARK;
                c.target = ST_MARK;
            end
            ST_CHK_RSVD: begin
                c.cond   = C_IS_RSVD;
                c.target = ST_IDLE;
            end
            ST_HASH: begin
                c.hash_en = 1'b1;
                c.cond    = C_NOT_LAST;
                c.target  = ST_IDLE;
            end
            ST_MOD_MUL: begin
                c.mod_mul = 1'b1;
            end
            ST_MOD_SUB: begin
                c.mod_sub = 1'b1;
            end
            ST_PROBE_INIT: begin
                c.probe_init = 1'b1;
            end
            ST_PROBE_READ: begin
                c.cond = C_NEXT;
            end
            ST_PROBE_CHK: begin
                c.cond   = C_SLOT_FREE;
                c.target = ST_EMIT_FOUND;
            end
            ST_PROBE_ADV: begin
                c.probe_adv = 1'b1;
                c.cond      = C_CNT_MORE;
                c.target    = ST_PROBE_READ;
            end
            ST_EMIT_FULL: begin
                c.emit_full = 1'b1;
                c.cond      = C_ALWAYS;
            end
            ST_EMIT_FOUND: begin
                c.emit_found = 1'b1;
                c.cond       = C_ALWAYS;
            end
            ST_MARK: begin
                c.mark_wr = 1'b1;
                c.cond    = C_ALWAYS;
            end
            default: begin
                c.cond = C_ALWAYS;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== sv/name_hash_slot_finder_top.sv =====
// ---------------------------------------------------------------------------
// name_hash_slot_finder_top: hashed slot search over an occupancy map
// A beat is taken when start is high and busy is low. A name-byte beat
// folds a nonzero byte into the running hash (hash * 13131 + signed byte); the
// beat flagged last_byte reduces the 31-bit hash modulo TABLE_SLOTS and
// probes forward, wrapping, for the first free slot. Mark beats set or
// clear one slot; indexes beyond the table are dropped.
// The sequencer runs one step per cycle. A name-byte beat that is not last,
// a mark or a reserved beat drops busy once its steps are done; a last byte
// ends in a result strobe when the probe finds a free slot, or in a
// table_full strobe once every slot was found used.
// The remainder takes two steps: a reciprocal multiply for the quotient
// estimate and a multiply-subtract, with one compare at probe setup. The
// probe reads each map entry through the registered read port, then checks
// it and advances. After reset busy stays high while the map is cleared
// one entry per cycle. Each result is shown for exactly one cycle on
// o_result with o_res_valid; the receiver cannot stall it.
// ---------------------------------------------------------------------------
module name_hash_slot_finder_top #(
    parameter int unsigned TABLE_SLOTS = nhsf_pkg::TABLE_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  nhsf_pkg::t_in  i_item,
    output logic           o_res_valid,
    output nhsf_pkg::t_out o_result
);

    nhsf_pkg::t_ctrl ctrl;
    nhsf_pkg::t_stat stat;

    // Sequencer
    nhsf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // Datapath and occupancy map
    nhsf_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    assign busy = ctrl.busy;

endmodule

// ===== sv/nhsf_seq.sv =====
// ---------------------------------------------------------------------------
// nhsf_seq: microprogram sequencer
// Step counter, control store lookup and conditional jump selection.
// ---------------------------------------------------------------------------
module nhsf_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nhsf_pkg::t_stat i_stat,
    output nhsf_pkg::t_ctrl o_ctrl
);

    nhsf_pkg::t_step r_pc;
    nhsf_pkg::t_step n_pc;
    logic            jump;

    // Fetch the control word of the current step
    assign o_ctrl = nhsf_pkg::ucode(r_pc);

    // Evaluate the jump condition
    always_comb begin
        case (o_ctrl.cond)
            nhsf_pkg::C_NEXT:      jump = 1'b0;
            nhsf_pkg::C_ALWAYS:    jump = 1'b1;
            nhsf_pkg::C_NOT_START: jump = !i_stat.start;
            nhsf_pkg::C_IS_MARK:   jump = i_stat.is_mark;
            nhsf_pkg::C_IS_RSVD:   jump = i_stat.is_rsvd;
            nhsf_pkg::C_NOT_LAST:  jump = i_stat.not_last;
            nhsf_pkg::C_SLOT_FREE: jump = i_stat.slot_free;
            nhsf_pkg::C_CNT_MORE:  jump = i_stat.cnt_more;
            default:               jump = 1'b1;
        endcase
        n_pc = jump ? o_ctrl.target : nhsf_pkg::t_step'(r_pc + 4'd1);
    end

    // Advance the step counter; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= nhsf_pkg::ST_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== sv/nhsf_dpath.sv =====
// ---------------------------------------------------------------------------
// nhsf_dpath: hash, remainder and probe datapath with the occupancy map
// Driven step by step by the control word from the sequencer.
// ---------------------------------------------------------------------------
module nhsf_dpath #(
    parameter int unsigned TABLE_SLOTS = nhsf_pkg::TABLE_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  nhsf_pkg::t_in   i_item,
    input  nhsf_pkg::t_ctrl i_ctrl,
    output nhsf_pkg::t_stat o_stat,
    output logic            o_res_valid,
    output nhsf_pkg::t_out  o_result
);

    localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned REM_W  = SLOT_W + 1;
    localparam int unsigned CNT_W  = (SLOT_W > 5) ? SLOT_W : 5;
    localparam int unsigned EXT_W  = nhsf_pkg::IDX_EXT_W;
    localparam int unsigned DVD_W  = nhsf_pkg::DVD_W;
    localparam int unsigned PROD_W = DVD_W + 32;
    localparam int unsigned QN_W   = DVD_W + EXT_W;
    // Table depth reciprocal scaled by 2^32; the quotient estimate is low by at most one
    localparam logic [31:0]      RECIP     = 32'((64'd1 << 32) / TABLE_SLOTS);
    localparam logic [EXT_W-1:0] SLOTS_EXT = EXT_W'(TABLE_SLOTS);

    nhsf_pkg::t_in               r_item;
    logic [31:0]                 r_hash;
    logic [DVD_W-1:0]            r_dvd;
    logic [DVD_W-1:0]            r_quo;
    logic [REM_W-1:0]            r_part;
    logic [SLOT_W-1:0]           r_pos;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_rd;
    logic                        r_res_valid;
    nhsf_pkg::t_out              r_result;

    logic                        slot_used [TABLE_SLOTS];

    logic [31:0]                 addend;
    logic [31:0]                 n_hash;
    logic [PROD_W-1:0]           recip_prod;
    logic [QN_W-1:0]             quo_prod;
    logic [31:0]                 part_diff;
    logic [SLOT_W-1:0]           n_rem;
    logic [SLOT_W-1:0]           pos_inc;
    logic [EXT_W-1:0]            idx_ext;
    logic [EXT_W-1:0]            pos_ext;
    logic                        idx_ok;
    logic                        wr_en;
    logic [SLOT_W-1:0]           wr_addr;
    logic                        wr_data;

    // Hash update: multiply, then add the sign-extended byte
    always_comb begin
        addend = {{24{r_item.name_byte[7]}}, r_item.name_byte};
        n_hash = (r_hash * nhsf_pkg::HASH_MULT) + addend;
    end

    // Remainder: reciprocal quotient estimate, multiply-subtract, one correction
    always_comb begin
        recip_prod = PROD_W'(r_hash[DVD_W-1:0]) * PROD_W'(RECIP);
        quo_prod   = QN_W'(r_quo) * QN_W'(SLOTS_EXT);
        part_diff  = 32'(r_dvd) - quo_prod[31:0];
        if (r_part >= REM_W'(TABLE_SLOTS)) begin
            n_rem = SLOT_W'(r_part - REM_W'(TABLE_SLOTS));
        end else begin
            n_rem = r_part[SLOT_W-1:0];
        end
    end

    // Next probe slot with wrap
    assign pos_inc = (r_pos == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : r_pos + 1'b1;

    // Slot index range check and map write port
    always_comb begin
        idx_ext = EXT_W'(r_item.slot_index);
        pos_ext = EXT_W'(r_pos);
        idx_ok  = idx_ext < SLOTS_EXT;
        wr_en   = i_ctrl.clr_wr || (i_ctrl.mark_wr && idx_ok);
        wr_addr = i_ctrl.clr_wr ? r_cnt[SLOT_W-1:0] : idx_ext[SLOT_W-1:0];
        wr_data = !i_ctrl.clr_wr && (r_item.operation == nhsf_pkg::OP_MARK_USED);
    end

    // Occupancy map: one write port, one registered read at the probe slot
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            slot_used[wr_addr] <= wr_data;
        end
        r_rd <= slot_used[r_pos];
    end

    // Latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch && i_start) begin
            r_item <= i_item;
        end
    end

    // Hash, remainder and probe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_ctrl.hash_en && (r_item.name_byte != 8'd0)) begin
                r_hash <= n_hash;
            end
            if (i_ctrl.mod_mul) begin
                r_hash <= '0;
                r_dvd  <= r_hash[DVD_W-1:0];
                r_quo  <= recip_prod[PROD_W-1:32];
            end
            if (i_ctrl.mod_sub) begin
                r_part <= part_diff[REM_W-1:0];
            end
            if (i_ctrl.probe_init) begin
                r_pos <= n_rem;
                r_cnt <= '0;
            end
            if (i_ctrl.probe_adv) begin
                r_pos <= pos_inc;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_ctrl.clr_wr) begin
                r_cnt <= (r_cnt == CNT_W'(TABLE_SLOTS - 1)) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // Result beat: strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_ctrl.emit_full || i_ctrl.emit_found;
        end
        if (i_ctrl.emit_full) begin
            r_result.descriptor <= '0;
            r_result.table_full <= 1'b1;
        end else if (i_ctrl.emit_found) begin
            r_result.descriptor <= pos_ext[nhsf_pkg::DESC_W-1:0];
            r_result.table_full <= 1'b0;
        end
    end

    // Status toward the sequencer
    always_comb begin
        o_stat.start     = i_start;
        o_stat.is_mark   = (r_item.operation == nhsf_pkg::OP_MARK_USED) ||
                           (r_item.operation == nhsf_pkg::OP_MARK_FREE);
        o_stat.is_rsvd   = (r_item.operation == nhsf_pkg::OP_RSVD);
        o_stat.not_last  = !r_item.last_byte;
        o_stat.slot_free = !r_rd;
        o_stat.cnt_more  = (r_cnt != CNT_W'(TABLE_SLOTS - 1));
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule
